/* hw/rtl/i2cm_pkg.sv */
// Package for the I2C master register access block: request/result types and codes.
package i2cm_pkg;

  localparam logic [7:0] ACK_WAIT_LIMIT_RESET = 8'd255;
  localparam int unsigned BITS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_t;

  typedef enum logic [17:0] {
    PH_IDLE      = 18'h00001,
    PH_START_A   = 18'h00002,
    PH_START_B   = 18'h00004,
    PH_START_C   = 18'h00008,
    PH_START_D   = 18'h00010,
    PH_WBIT_SET  = 18'h00020,
    PH_WBIT_HIGH = 18'h00040,
    PH_WBIT_LOW  = 18'h00080,
    PH_WREL      = 18'h00100,
    PH_ACK_RISE  = 18'h00200,
    PH_ACK_WAIT  = 18'h00400,
    PH_RBIT_HIGH = 18'h00800,
    PH_RBIT_LOW  = 18'h01000,
    PH_RREL      = 18'h02000,
    PH_STOP_A    = 18'h04000,
    PH_STOP_B    = 18'h08000,
    PH_STOP_C    = 18'h10000,
    PH_STOP_D    = 18'h20000
  } phase_t;

  // Which byte of the transaction is on the bus.
  typedef enum logic [2:0] {
    ST_DEV  = 3'd0,
    ST_WORD = 3'd1,
    ST_DATA = 3'd2,
    ST_DEV2 = 3'd3,
    ST_READ = 3'd4
  } stage_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] device_addr;
    logic [7:0] word_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_data;
  } out_t;

endpackage

/* hw/rtl/i2cm_seq.sv */
// Bit-level I2C sequencer: one pin step per accepted request.
module i2cm_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  i2cm_pkg::in_t req,
  input  logic [7:0]    ack_wait_limit,
  output i2cm_pkg::out_t res_next
);
  import i2cm_pkg::*;

  phase_t     phase, phase_next;
  stage_t     stage, stage_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_reg, shift_reg_next;
  logic [7:0] ack_wait_count, ack_wait_count_next;
  logic [7:0] held_device_addr, held_device_addr_next;
  logic [7:0] held_word_addr, held_word_addr_next;
  logic [7:0] held_write_data, held_write_data_next;
  logic       is_read, is_read_next;
  logic       scl_level, scl_level_next;
  logic       sda_level, sda_level_next;
  logic       done_read;
  logic [3:0] bit_inc;

  assign bit_inc = bit_count + 4'd1;

  always_comb begin
    phase_next            = phase;
    stage_next            = stage;
    bit_count_next        = bit_count;
    shift_reg_next        = shift_reg;
    ack_wait_count_next   = ack_wait_count;
    held_device_addr_next = held_device_addr;
    held_word_addr_next   = held_word_addr;
    held_write_data_next  = held_write_data;
    is_read_next          = is_read;
    scl_level_next        = scl_level;
    sda_level_next        = sda_level;
    done_read             = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (req.mode == MODE_WRITE || req.mode == MODE_READ) begin
          held_device_addr_next = req.device_addr;
          held_word_addr_next   = req.word_addr;
          held_write_data_next  = req.write_data;
          is_read_next          = (req.mode == MODE_READ);
          stage_next            = ST_DEV;
          scl_level_next        = 1'b0;
          sda_level_next        = 1'b1;
          phase_next            = PH_START_B;
        end
      end
      PH_START_A: begin
        scl_level_next = 1'b0;
        sda_level_next = 1'b1;
        phase_next     = PH_START_B;
      end
      PH_START_B: begin
        scl_level_next = 1'b1;
        phase_next     = PH_START_C;
      end
      PH_START_C: begin
        sda_level_next = 1'b0;
        phase_next     = PH_START_D;
      end
      PH_START_D: begin
        scl_level_next = 1'b0;
        shift_reg_next = (stage == ST_DEV2) ? held_device_addr + 8'd1 : held_device_addr;
        bit_count_next = '0;
        phase_next     = PH_WBIT_SET;
      end
      PH_WBIT_SET: begin
        sda_level_next = shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        phase_next     = PH_WBIT_HIGH;
      end
      PH_WBIT_HIGH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_WBIT_LOW;
      end
      PH_WBIT_LOW: begin
        scl_level_next = 1'b0;
        bit_count_next = bit_inc;
        phase_next     = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_WREL : PH_WBIT_SET;
      end
      PH_WREL: begin
        sda_level_next = 1'b1;
        phase_next     = PH_ACK_RISE;
      end
      PH_ACK_RISE: begin
        scl_level_next      = 1'b1;
        ack_wait_count_next = '0;
        phase_next          = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (req.sda_in && ack_wait_count < ack_wait_limit) begin
          ack_wait_count_next = ack_wait_count + 8'd1;
        end else begin
          scl_level_next = 1'b0;
          case (stage)
            ST_DEV: begin
              stage_next     = ST_WORD;
              shift_reg_next = held_word_addr;
              bit_count_next = '0;
              phase_next     = PH_WBIT_SET;
            end
            ST_WORD: begin
              if (is_read) begin
                stage_next = ST_DEV2;
                phase_next = PH_START_A;
              end else begin
                stage_next     = ST_DATA;
                shift_reg_next = held_write_data;
                bit_count_next = '0;
                phase_next     = PH_WBIT_SET;
              end
            end
            ST_DEV2: begin
              stage_next     = ST_READ;
              bit_count_next = '0;
              phase_next     = PH_RBIT_HIGH;
            end
            default: phase_next = PH_STOP_A;
          endcase
        end
      end
      PH_RBIT_HIGH: begin
        scl_level_next = 1'b1;
        phase_next     = PH_RBIT_LOW;
      end
      PH_RBIT_LOW: begin
        shift_reg_next = {shift_reg[6:0], req.sda_in};
        scl_level_next = 1'b0;
        bit_count_next = bit_inc;
        phase_next     = (bit_inc >= 4'(BITS_PER_BYTE)) ? PH_RREL : PH_RBIT_HIGH;
      end
      PH_RREL: begin
        sda_level_next = 1'b1;  // NACK the read byte
        phase_next     = PH_STOP_A;
      end
      PH_STOP_A: begin
        sda_level_next = 1'b0;
        phase_next     = PH_STOP_B;
      end
      PH_STOP_B: begin
        scl_level_next = 1'b1;
        phase_next     = PH_STOP_C;
      end
      PH_STOP_C: begin
        sda_level_next = 1'b1;
        phase_next     = PH_STOP_D;
      end
      PH_STOP_D: begin
        scl_level_next = 1'b0;
        done_read      = is_read && (stage == ST_READ);
        stage_next     = ST_DEV;
        phase_next     = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        stage_next = ST_DEV;
      end
    endcase
  end

  always_comb begin
    res_next.scl_out    = scl_level_next;
    res_next.sda_out    = sda_level_next;
    res_next.busy_res   = (phase_next != PH_IDLE);
    res_next.read_valid = done_read;
    res_next.read_data  = done_read ? shift_reg_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      stage            <= ST_DEV;
      bit_count        <= '0;
      shift_reg        <= '0;
      ack_wait_count   <= '0;
      held_device_addr <= '0;
      held_word_addr   <= '0;
      held_write_data  <= '0;
      is_read          <= 1'b0;
      scl_level        <= 1'b1;
      sda_level        <= 1'b1;
    end else if (advance) begin
      phase            <= phase_next;
      stage            <= stage_next;
      bit_count        <= bit_count_next;
      shift_reg        <= shift_reg_next;
      ack_wait_count   <= ack_wait_count_next;
      held_device_addr <= held_device_addr_next;
      held_word_addr   <= held_word_addr_next;
      held_write_data  <= held_write_data_next;
      is_read          <= is_read_next;
      scl_level        <= scl_level_next;
      sda_level        <= sda_level_next;
    end
  end

  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= 4'(BITS_PER_BYTE))
    else $error("bit counter past one byte");

  a_idle_stage: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> stage == ST_DEV)
    else $error("idle with a byte stage left over");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    advance && res_next.read_valid |=> phase == PH_IDLE && !is_read == 1'b0)
    else $error("read completion without return to idle");

endmodule

/* hw/rtl/i2c_master_register_access.sv */
// Top level of the bit-level I2C master that reads or writes one register byte.
//
//   channel | signals                    | accepted when
//   --------+----------------------------+------------------------------
//   request | in_valid/in_ready/in_data  | in_valid && in_ready
//   result  | out_valid/out_ready/out_data | out_valid && out_ready
//   config  | cfg_we/cfg_wdata           | cfg_we (ack_wait_limit)
//
// Each request is one bus tick and yields exactly one result in the following cycle.
// A request can be accepted every cycle while results are taken; the pace is set
// by the single pass through the sequencer's next-step logic into the result register.
// The result register is reloaded in the cycle it is taken, so a stalled
// consumer blocks requests only while the held result is not taken.
// Synchronous reset: bus released (SCL and SDA high), idle, ack limit 255.
module i2c_master_register_access (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  i2cm_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output i2cm_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);
  import i2cm_pkg::*;

  logic [7:0] ack_wait_limit;
  logic       advance;
  out_t       res_next;

  // Result slot free, or being emptied this cycle.
  assign in_ready = !out_valid || out_ready;
  assign advance  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= ACK_WAIT_LIMIT_RESET;
    end else if (cfg_we) begin
      ack_wait_limit <= cfg_wdata;
    end
  end

  i2cm_seq u_seq (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .req            (in_data),
    .ack_wait_limit (ack_wait_limit),
    .res_next       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res_next;
    end
  end

  a_read_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.read_valid |-> !out_data.busy_res)
    else $error("read result flagged while still busy");

  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid))
    else $error("result appeared without a request");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("held result changed or dropped");

endmodule

/* tb/i2c_master_register_access_tb.sv */
// Testbench for the bit-level I2C master: bus-step predictor, scoreboard and test sequences.
`timescale 1ns / 100ps

module i2c_master_register_access_tb;
  import i2cm_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;     // long consumer stall for the back-pressure test
  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;

  logic           clk       = 1'b0;
  logic           rst       = 1'b1;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  in_t            in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  out_t           out_data;
  logic           cfg_we    = 1'b0;
  logic [7:0]     cfg_wdata = 8'h00;

  // Stimulus knobs. tx_idle_pct is only used by the driving process; rx_idle_pct
  // and long_hold are read by the consumer process.
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic long_hold   = 1'b0;
  int   hold_count  = 0;

  int   items_sent  = 0;
  int   fail_count  = 0;
  int   cycle_count = 0;

  i2c_master_register_access u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bus-step predictor. One call per accepted request; the pin levels that the
  // sequencer drives after that step go into bus_levels_q.
  // ---------------------------------------------------------------------------
  phase_t     m_phase;
  stage_t     m_stage;
  logic [3:0] m_bits;
  logic [7:0] m_shift;
  logic [7:0] m_ack_count;
  logic [7:0] m_ack_limit;
  logic [7:0] m_dev;
  logic [7:0] m_word;
  logic [7:0] m_data;
  logic       m_read;
  logic       m_scl;
  logic       m_sda;
  out_t       bus_levels_q[$];

  // Queue a byte for the MSB-first shifter.
  task automatic shift_out(input logic [7:0] b);
    m_shift = b;
    m_bits  = 4'd0;
    m_phase = PH_WBIT_SET;
  endtask

  task automatic advance_bus(input in_t req);
    out_t exp;
    logic done_read;
    done_read = 1'b0;
    case (m_phase)
      PH_IDLE: begin
        // Only an idle bus takes a command; mode 3 is a plain tick.
        if (req.mode == MODE_WRITE || req.mode == MODE_READ) begin
          m_dev   = req.device_addr;
          m_word  = req.word_addr;
          m_data  = req.write_data;
          m_read  = (req.mode == MODE_READ);
          m_stage = ST_DEV;
          m_scl   = 1'b0;
          m_sda   = 1'b1;
          m_phase = PH_START_B;
        end
      end
      PH_START_A: begin
        m_scl   = 1'b0;
        m_sda   = 1'b1;
        m_phase = PH_START_B;
      end
      PH_START_B: begin
        m_scl   = 1'b1;
        m_phase = PH_START_C;
      end
      PH_START_C: begin
        m_sda   = 1'b0;
        m_phase = PH_START_D;
      end
      PH_START_D: begin
        m_scl = 1'b0;
        // Repeated start sends the read address; +1 wraps in 8 bits.
        if (m_stage == ST_DEV2) begin
          shift_out(m_dev + 8'd1);
        end else begin
          shift_out(m_dev);
        end
      end
      PH_WBIT_SET: begin
        m_sda   = m_shift[7];
        m_shift = {m_shift[6:0], 1'b0};
        m_phase = PH_WBIT_HIGH;
      end
      PH_WBIT_HIGH: begin
        m_scl   = 1'b1;
        m_phase = PH_WBIT_LOW;
      end
      PH_WBIT_LOW: begin
        m_scl   = 1'b0;
        m_bits  = m_bits + 4'd1;
        m_phase = (m_bits >= BITS_PER_BYTE) ? PH_WREL : PH_WBIT_SET;
      end
      PH_WREL: begin
        m_sda   = 1'b1;
        m_phase = PH_ACK_RISE;
      end
      PH_ACK_RISE: begin
        m_scl       = 1'b1;
        m_ack_count = 8'd0;
        m_phase     = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        // SCL stays high while SDA reads high, up to the limit; ACK or not, go on.
        if (req.sda_in && m_ack_count < m_ack_limit) begin
          m_ack_count = m_ack_count + 8'd1;
        end else begin
          m_scl = 1'b0;
          case (m_stage)
            ST_DEV: begin
              m_stage = ST_WORD;
              shift_out(m_word);
            end
            ST_WORD: begin
              if (m_read) begin
                m_stage = ST_DEV2;
                m_phase = PH_START_A;
              end else begin
                m_stage = ST_DATA;
                shift_out(m_data);
              end
            end
            ST_DEV2: begin
              m_stage = ST_READ;
              m_bits  = 4'd0;
              m_phase = PH_RBIT_HIGH;
            end
            default: begin
              m_phase = PH_STOP_A;
            end
          endcase
        end
      end
      PH_RBIT_HIGH: begin
        m_scl   = 1'b1;
        m_phase = PH_RBIT_LOW;
      end
      PH_RBIT_LOW: begin
        m_shift = {m_shift[6:0], req.sda_in};
        m_scl   = 1'b0;
        m_bits  = m_bits + 4'd1;
        m_phase = (m_bits >= BITS_PER_BYTE) ? PH_RREL : PH_RBIT_HIGH;
      end
      PH_RREL: begin
        // SDA released after the read byte: NACK.
        m_sda   = 1'b1;
        m_phase = PH_STOP_A;
      end
      PH_STOP_A: begin
        m_sda   = 1'b0;
        m_phase = PH_STOP_B;
      end
      PH_STOP_B: begin
        m_scl   = 1'b1;
        m_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        m_sda   = 1'b1;
        m_phase = PH_STOP_D;
      end
      PH_STOP_D: begin
        // SCL is left low on the idle bus.
        m_scl     = 1'b0;
        done_read = m_read && (m_stage == ST_READ);
        m_stage   = ST_DEV;
        m_phase   = PH_IDLE;
      end
      default: begin
        m_phase = PH_IDLE;
        m_stage = ST_DEV;
      end
    endcase
    exp.scl_out    = m_scl;
    exp.sda_out    = m_sda;
    exp.busy_res   = (m_phase != PH_IDLE);
    exp.read_valid = done_read;
    exp.read_data  = done_read ? m_shift : 8'h00;
    bus_levels_q.push_back(exp);
  endtask

  // ---------------------------------------------------------------------------
  // Request driver. Valid stays up across back-to-back requests; a random gap
  // drops it first. The request is predicted at the edge where it is taken.
  // ---------------------------------------------------------------------------
  task automatic send_request(input in_t req);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    advance_bus(req);
    items_sent++;
  endtask

  // One bus tick with random payload. cmd_pct: chance of a random mode (commands
  // while busy must be ignored). ack_pct: chance the slave pulls SDA low while
  // the master waits for an acknowledge.
  function automatic in_t make_tick(input int cmd_pct, input int ack_pct);
    in_t req;
    req.device_addr = 8'($urandom);
    req.word_addr   = 8'($urandom);
    req.write_data  = 8'($urandom);
    if ($urandom_range(99) < cmd_pct) begin
      req.mode = 2'($urandom_range(3));
    end else begin
      req.mode = MODE_TICK;
    end
    if (m_phase == PH_ACK_WAIT) begin
      req.sda_in = ($urandom_range(99) >= ack_pct);
    end else begin
      req.sda_in = 1'($urandom_range(1));
    end
    return req;
  endfunction

  // Tick until the predicted bus is idle again.
  task automatic finish_frame(input int ack_pct, input int cmd_pct);
    while (m_phase != PH_IDLE) send_request(make_tick(cmd_pct, ack_pct));
  endtask

  // A whole transaction: the command tick, then ticks until the stop is done.
  task automatic run_transaction(input mode_t kind, input logic [7:0] dev,
                                 input logic [7:0] word, input logic [7:0] data,
                                 input int ack_pct, input int cmd_pct);
    in_t req;
    req             = make_tick(0, ack_pct);
    req.mode        = kind;
    req.device_addr = dev;
    req.word_addr   = word;
    req.write_data  = data;
    send_request(req);
    finish_frame(ack_pct, cmd_pct);
  endtask

  task automatic wait_drained();
    while (bus_levels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write only once every pending result has come back.
  task automatic set_ack_limit(input logic [7:0] value);
    in_valid <= 1'b0;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    m_ack_limit = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result consumer: random stalls, plus a long counted hold on request.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      hold_count <= 0;
    end else if (long_hold && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
      if (!long_hold) begin
        hold_count <= 0;
      end
    end
  end

  // Scoreboard: each taken result against the oldest predicted one.
  out_t want;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (bus_levels_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("unexpected result: scl=%b sda=%b busy=%b rv=%b rd=%h",
                   out_data.scl_out, out_data.sda_out, out_data.busy_res,
                   out_data.read_valid, out_data.read_data);
        end
      end else begin
        want = bus_levels_q.pop_front();
        if (out_data.scl_out !== want.scl_out || out_data.sda_out !== want.sda_out ||
            out_data.busy_res !== want.busy_res ||
            out_data.read_valid !== want.read_valid ||
            out_data.read_data !== want.read_data) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("mismatch: exp scl=%b sda=%b busy=%b rv=%b rd=%h",
                     want.scl_out, want.sda_out, want.busy_res,
                     want.read_valid, want.read_data);
            $display("          got scl=%b sda=%b busy=%b rv=%b rd=%h",
                     out_data.scl_out, out_data.sda_out, out_data.busy_res,
                     out_data.read_valid, out_data.read_data);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("i2c_master_register_access_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Idle bus: plain ticks and the reserved mode 3, which is only a tick.
  task automatic test_idle_ticks();
    in_t req;
    req = '0;
    send_request(req);
    req = '1;
    req.mode = MODE_RSVD;
    send_request(req);
    req.mode = MODE_TICK;
    send_request(req);
  endtask

  // Writes with field extremes, fast ACKs, then a slave that is slow to ACK.
  task automatic test_write_frames();
    run_transaction(MODE_WRITE, 8'h00, 8'h00, 8'h00, 100, 0);
    run_transaction(MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 100, 0);
    run_transaction(MODE_WRITE, 8'hA4, 8'h5A, 8'h3C, 40, 0);
  endtask

  // Reads; device address 0xFF checks the +1 wrap to 0x00.
  task automatic test_read_frames();
    run_transaction(MODE_READ, 8'hFF, 8'h00, 8'h00, 100, 0);
    run_transaction(MODE_READ, 8'hA0, 8'h7E, 8'hFF, 100, 0);
  endtask

  // Every tick of the frame carries a random command; all must be ignored.
  task automatic test_busy_commands();
    run_transaction(MODE_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 70, 100);
    run_transaction(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), 70, 100);
  endtask

  // ACK limit extremes: zero (SCL high one tick only) and 255 with no ACK at all, then a limit of 1.
  task automatic test_ack_limits();
    set_ack_limit(8'd0);
    run_transaction(MODE_WRITE, 8'h50, 8'h0F, 8'hF0, 0, 0);
    run_transaction(MODE_READ, 8'h51, 8'hF0, 8'h0F, 0, 0);
    set_ack_limit(8'd255);
    run_transaction(MODE_READ, 8'h41, 8'h22, 8'h00, 0, 0);
    set_ack_limit(8'd1);
    run_transaction(MODE_WRITE, 8'h3E, 8'hC1, 8'h99, 50, 0);
  endtask

  // Consumer holds off for HOLD_CYCLES while requests keep coming: the block
  // fills and must stall its request side without losing anything.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    long_hold   <= 1'b1;
    run_transaction(MODE_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 100, 10);
    long_hold   <= 1'b0;
  endtask

  // Mostly well-formed frames with random content, some noise bursts; the
  // ACK limit changes between blocks of traffic.
  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input int n_items);
    int first;
    int next_cfg;
    int r;
    int ack_pct;
    int cmd_pct;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    first    = items_sent;
    next_cfg = first;
    while (items_sent - first < n_items) begin
      if (items_sent >= next_cfg) begin
        finish_frame(100, 0);
        case ($urandom_range(3))
          0:       set_ack_limit(8'd0);
          1:       set_ack_limit(8'd255);
          2:       set_ack_limit(8'($urandom_range(1, 6)));
          default: set_ack_limit(8'($urandom_range(255)));
        endcase
        next_cfg = items_sent + n_items / 3;
      end
      case ($urandom_range(3))
        0:       ack_pct = 100;
        1:       ack_pct = 70;
        2:       ack_pct = 30;
        default: ack_pct = 5;
      endcase
      cmd_pct = ($urandom_range(1) != 0) ? 10 : 0;
      r = $urandom_range(99);
      if (r < 80) begin
        run_transaction(($urandom_range(1) != 0) ? MODE_READ : MODE_WRITE,
                        8'($urandom), 8'($urandom), 8'($urandom), ack_pct, cmd_pct);
      end else if (r < 92) begin
        // Noise: random modes at random points, may start a frame anywhere.
        repeat ($urandom_range(1, 10)) send_request(make_tick(50, 50));
      end else begin
        repeat ($urandom_range(2, 5)) send_request(make_tick(0, ack_pct));
      end
    end
    finish_frame(100, 0);
  endtask

  initial begin
    // Predictor reset state matches the block after reset.
    m_phase     = PH_IDLE;
    m_stage     = ST_DEV;
    m_bits      = 4'd0;
    m_shift     = 8'h00;
    m_ack_count = 8'h00;
    m_ack_limit = ACK_WAIT_LIMIT_RESET;
    m_dev       = 8'h00;
    m_word      = 8'h00;
    m_data      = 8'h00;
    m_read      = 1'b0;
    m_scl       = 1'b1;
    m_sda       = 1'b1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_ticks();
    test_write_frames();
    test_read_frames();
    test_busy_commands();
    test_ack_limits();
    test_backpressure();
    test_random_traffic(19, 70, RANDOM_ITEMS / 3);
    test_random_traffic(70, 19, RANDOM_ITEMS / 3);
    test_random_traffic(0, 0, RANDOM_ITEMS / 3);

    in_valid <= 1'b0;
    wait_drained();

    fail_count += bus_levels_q.size();
    if (fail_count == 0) begin
      $display("i2c_master_register_access_tb: PASS");
    end else begin
      $display("i2c_master_register_access_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_master_register_access.sv
tb/i2c_master_register_access_tb.sv
